FILE: src/tbpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile background pixel fetch package
// Shared types, item codes and store geometry for the background fetch block.
// ----------------------------------------------------------------------------
package tbpf_pkg;

  localparam int VISIBLE_LINES_DEF = 240;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int NAME_DEPTH  = 1024;
  localparam int PAT_DEPTH   = 8192;
  localparam int COLOR_DEPTH = 16;
  localparam int NAME_AW     = $clog2(NAME_DEPTH);
  localparam int PAT_AW      = $clog2(PAT_DEPTH);
  localparam int COLOR_AW    = $clog2(COLOR_DEPTH);

  // The attribute area starts at 32 * 30 = 960, which is 15 rows of 64 bytes.
  localparam logic [3:0] ATTR_BLOCK = 4'(32 * 30 / 64);

  typedef enum logic [1:0] {
    OP_NAME_WR  = 2'd0,
    OP_PAT_WR   = 2'd1,
    OP_COLOR_WR = 2'd2,
    OP_RENDER   = 2'd3
  } op_t;

  typedef struct packed {
    op_t         kind;
    logic [12:0] addr;
    logic [31:0] value;
    logic [7:0]  x;
    logic [7:0]  y;
  } item_t;

endpackage

FILE: src/tbpf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input request channel
// Valid/ready channel carrying one write or render request.
// ----------------------------------------------------------------------------
interface tbpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [12:0] write_address;
  logic [31:0] write_value;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;

  modport source (output valid, op, write_address, write_value, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, op, write_address, write_value, pixel_x, pixel_y,
                output ready);
endinterface

FILE: src/tbpf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output pixel channel
// Valid/ready channel carrying one rendered background pixel.
// ----------------------------------------------------------------------------
interface tbpf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_color;
  logic [3:0]  color_index;

  modport source (output valid, pixel_color, color_index, input ready);
  modport sink (input valid, pixel_color, color_index, output ready);
endinterface

FILE: src/tbpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests and drops those with no effect before they reach the queue.
// ----------------------------------------------------------------------------
module tbpf_front #(
  parameter int VISIBLE_LINES = tbpf_pkg::VISIBLE_LINES_DEF
) (
  tbpf_in_if.sink         in_chan,
  input  logic            queue_full,
  output logic            push,
  output tbpf_pkg::item_t push_item
);

  logic keep;

  assign in_chan.ready = !queue_full;

  always_comb begin
    push_item.kind  = tbpf_pkg::op_t'(in_chan.op);
    push_item.addr  = in_chan.write_address;
    push_item.value = in_chan.write_value;
    push_item.x     = in_chan.pixel_x;
    push_item.y     = in_chan.pixel_y;
    case (push_item.kind)
      tbpf_pkg::OP_NAME_WR: begin
        keep = (in_chan.write_address[12:tbpf_pkg::NAME_AW] == '0);
      end
      tbpf_pkg::OP_PAT_WR: begin
        keep = 1'b1;
      end
      tbpf_pkg::OP_COLOR_WR: begin
        keep = (in_chan.write_address[12:tbpf_pkg::COLOR_AW] == '0);
      end
      tbpf_pkg::OP_RENDER: begin
        keep = ({1'b0, in_chan.pixel_y} < 9'(VISIBLE_LINES));
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_chan.valid && in_chan.ready && keep;

endmodule

FILE: src/tbpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request queue
// Small FIFO that decouples the front end from the fetch pipeline.
// ----------------------------------------------------------------------------
module tbpf_queue #(
  parameter int DEPTH = tbpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tbpf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tbpf_pkg::item_t head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tbpf_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/tbpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fetch pipeline
// Three stages: name table, pattern planes, color store. Each write is applied
// at the stage that reads its store, so every store sees requests in order.
// ----------------------------------------------------------------------------
module tbpf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            half_select,
  input  logic            head_valid,
  input  tbpf_pkg::item_t head_item,
  output logic            pop,
  tbpf_out_if.source      out_chan
);

  logic [7:0]  name_mem  [tbpf_pkg::NAME_DEPTH];
  logic [7:0]  pat_mem   [tbpf_pkg::PAT_DEPTH];
  logic [31:0] color_mem [tbpf_pkg::COLOR_DEPTH];

  logic adv;

  logic            s1_valid_r;
  tbpf_pkg::item_t s1_item_r;
  logic [7:0]      tile_r;
  logic [7:0]      attr_r;

  logic            s2_valid_r;
  tbpf_pkg::op_t   s2_kind_r;
  logic [12:0]     s2_addr_r;
  logic [31:0]     s2_value_r;
  logic [2:0]      s2_col_r;
  logic [1:0]      high_r;
  logic [7:0]      plane0_r;
  logic [7:0]      plane1_r;

  logic            out_valid_r;
  logic [31:0]     color_r;
  logic [3:0]      index_r;

  logic [tbpf_pkg::NAME_AW-1:0]  tile_addr;
  logic [tbpf_pkg::NAME_AW-1:0]  attr_addr;
  logic [tbpf_pkg::PAT_AW-1:0]   row0_addr;
  logic [tbpf_pkg::PAT_AW-1:0]   row1_addr;
  logic [1:0]                    high;
  logic [1:0]                    low;
  logic [3:0]                    index;
  logic [tbpf_pkg::COLOR_AW-1:0] entry;

  assign adv = !out_valid_r || out_chan.ready;
  assign pop = adv && head_valid;

  assign tile_addr = {head_item.y[7:3], head_item.x[7:3]};
  assign attr_addr = {tbpf_pkg::ATTR_BLOCK, head_item.y[7:5], head_item.x[7:5]};

  always_ff @(posedge clk) begin
    if (adv) begin
      tile_r    <= name_mem[tile_addr];
      attr_r    <= name_mem[attr_addr];
      s1_item_r <= head_item;
      if (head_valid && head_item.kind == tbpf_pkg::OP_NAME_WR) begin
        name_mem[head_item.addr[tbpf_pkg::NAME_AW-1:0]] <= head_item.value[7:0];
      end
    end
  end

  assign row0_addr = {half_select, tile_r, 1'b0, s1_item_r.y[2:0]};
  assign row1_addr = {half_select, tile_r, 1'b1, s1_item_r.y[2:0]};
  assign high      = attr_r[{s1_item_r.y[4], s1_item_r.x[4], 1'b0} +: 2];

  always_ff @(posedge clk) begin
    if (adv) begin
      plane0_r   <= pat_mem[row0_addr];
      plane1_r   <= pat_mem[row1_addr];
      high_r     <= high;
      s2_kind_r  <= s1_item_r.kind;
      s2_addr_r  <= s1_item_r.addr;
      s2_value_r <= s1_item_r.value;
      s2_col_r   <= s1_item_r.x[2:0];
      if (s1_valid_r && s1_item_r.kind == tbpf_pkg::OP_PAT_WR) begin
        pat_mem[s1_item_r.addr] <= s1_item_r.value[7:0];
      end
    end
  end

  assign low   = {plane1_r[~s2_col_r], plane0_r[~s2_col_r]};
  assign index = {high_r, low};
  assign entry = (low == 2'b00) ? '0 : index;

  always_ff @(posedge clk) begin
    if (adv) begin
      color_r <= color_mem[entry];
      index_r <= index;
      if (s2_valid_r && s2_kind_r == tbpf_pkg::OP_COLOR_WR) begin
        color_mem[s2_addr_r[tbpf_pkg::COLOR_AW-1:0]] <= s2_value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= head_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && (s2_kind_r == tbpf_pkg::OP_RENDER);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_color = color_r;
  assign out_chan.color_index = index_r;

endmodule

FILE: src/tile_background_pixel_fetch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile background pixel fetch
// Background renderer without scrolling: stores writes into the name table,
// pattern store and color store, and renders one pixel per render request on a visible line.
//
//   Channel   Dir   Handshake       Payload
//   in_chan   in    valid / ready   op, write_address, write_value, pixel_x, pixel_y
//   out_chan  out   valid / ready   pixel_color, color_index
//   cfg       in    cfg_we          cfg_wdata (pattern half select)
//
// One request is accepted per cycle while the queue is not full; a render pixel
// passes through the queue and then the registered name table, pattern plane
// and color store reads before it appears. Reset is synchronous and clears only
// control state; the stores are not cleared. When the output is stalled the
// pipeline holds and the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch #(
  parameter int VISIBLE_LINES = tbpf_pkg::VISIBLE_LINES_DEF,
  parameter int QUEUE_DEPTH   = tbpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  tbpf_in_if.sink    in_chan,
  tbpf_out_if.source out_chan
);

  logic            half_r;
  logic            queue_full;
  logic            push;
  tbpf_pkg::item_t push_item;
  logic            pop;
  logic            head_valid;
  tbpf_pkg::item_t head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
    end else if (cfg_we) begin
      half_r <= cfg_wdata;
    end
  end

  tbpf_front #(
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_front (
    .in_chan    (in_chan),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  tbpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tbpf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .half_select (half_r),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule

FILE: src/tbpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile background pixel fetch checker
// Port-level checks on reset behavior and the output channel.
// ----------------------------------------------------------------------------
module tbpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_color,
  input logic [3:0]  out_index
);

  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_reset_in_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("Input not ready after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Output request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_color) && $stable(out_index))
    else $error("Output payload changed while stalled.");

endmodule

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_color (out_chan.pixel_color),
  .out_index (out_chan.color_index)
);
